@@ hw/rtl/drq_pkg.sv @@
// Shared types and constants for the dedup ring queue.
package drq_pkg;

    localparam int CAPACITY = 64;

    // APB byte address of the keep_limit register
    localparam logic [1:0] ADDR_KEEP_LIMIT = 2'd0;

    typedef enum logic [2:0] {
        REQ_PUSH  = 3'd0,
        REQ_PEEK  = 3'd1,
        REQ_POP   = 3'd2,
        REQ_CLEAR = 3'd3,
        REQ_RDAY  = 3'd4
    } req_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_SCAN,
        S_APPEND,
        S_RDAY,
        S_RESP
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic accept;
        logic exec;
        logic scan;
        logic append;
        logic rday;
        logic rday_fin;
        logic load;
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic hit;
        logic rd_done;
        logic rvalid;
        logic out_free;
    } sts_t;

endpackage

@@ hw/rtl/drq_ctrl.sv @@
// Sequencer for the dedup ring queue: one request at a time.
module drq_ctrl
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic [2:0]       req_type,
    input  drq_pkg::sts_t    sts,
    output drq_pkg::cmd_t    cmd,
    output logic             in_stall
);

    drq_pkg::state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= drq_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_stall   = 1'b1;
        case (state_reg)
            drq_pkg::S_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    case (req_type)
                        drq_pkg::REQ_PUSH: state_next = drq_pkg::S_SCAN;
                        drq_pkg::REQ_RDAY: state_next = drq_pkg::S_RDAY;
                        default:           state_next = drq_pkg::S_EXEC;
                    endcase
                end
            end
            drq_pkg::S_EXEC:
            begin
                cmd.exec   = 1'b1;
                state_next = drq_pkg::S_RESP;
            end
            drq_pkg::S_SCAN:
            begin
                cmd.scan = 1'b1;
                if (sts.hit)
                begin
                    state_next = drq_pkg::S_RESP;
                end
                else if (sts.rd_done && !sts.rvalid)
                begin
                    state_next = drq_pkg::S_APPEND;
                end
            end
            drq_pkg::S_APPEND:
            begin
                cmd.append = 1'b1;
                state_next = drq_pkg::S_RESP;
            end
            drq_pkg::S_RDAY:
            begin
                cmd.rday = 1'b1;
                if (sts.rd_done && !sts.rvalid)
                begin
                    cmd.rday_fin = 1'b1;
                    state_next   = drq_pkg::S_RESP;
                end
            end
            drq_pkg::S_RESP:
            begin
                if (sts.out_free)
                begin
                    cmd.load   = 1'b1;
                    state_next = drq_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = drq_pkg::S_IDLE;
            end
        endcase
    end

    a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        $countones({cmd.accept, cmd.exec, cmd.append, cmd.load}) <= 1)
        else $error("more than one step command at once");
    a_fin_in_rday: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.rday_fin |-> cmd.rday)
        else $error("remove-day finish outside remove-day");
    a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> !in_stall)
        else $error("not idle after result load");

endmodule

@@ hw/rtl/drq_dp.sv @@
// Datapath: entry store, ring pointers, counters and result register.
module drq_dp
#(
    parameter int CAPACITY = drq_pkg::CAPACITY,
    localparam int AW = $clog2(CAPACITY),
    localparam int CW = $clog2(CAPACITY + 1)
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  drq_pkg::cmd_t    cmd,
    output drq_pkg::sts_t    sts,
    input  logic [15:0]      keep_limit,
    input  logic [2:0]       req_type,
    input  logic [31:0]      entry_day,
    input  logic [15:0]      entry_index,
    input  logic [15:0]      peek_position,
    input  logic [15:0]      pop_count,
    input  logic             out_stall,
    output logic             out_valid,
    output logic             ok,
    output logic             was_present,
    output logic [31:0]      out_day,
    output logic [15:0]      out_index,
    output logic [CW-1:0]    queue_count,
    output logic [31:0]      drops
);

    function automatic logic [AW-1:0] ring(input logic [CW:0] s);
        logic [CW:0] r;
        r = s;
        if (s >= (CW+1)'(CAPACITY))
        begin
            r = s - (CW+1)'(CAPACITY);
        end
        return r[AW-1:0];
    endfunction

    logic [47:0]   mem [CAPACITY];
    logic [2:0]    req_reg;
    logic [31:0]   day_reg;
    logic [15:0]   idx_reg;
    logic [15:0]   pos_reg;
    logic [15:0]   n_reg;
    logic [AW-1:0] head_reg;
    logic [CW-1:0] fill_reg;
    logic [31:0]   drop_reg;
    logic [CW-1:0] rd_pos_reg;
    logic [CW-1:0] kept_reg;
    logic          rvalid_reg;
    logic [47:0]   rdata_reg;
    logic          dup_reg;
    logic          out_valid_reg;
    logic          ok_reg;
    logic          pres_reg;
    logic [31:0]   oday_reg;
    logic [15:0]   oidx_reg;

    logic          rd_done;
    logic          issue;
    logic [AW-1:0] raddr;
    logic          we;
    logic [AW-1:0] waddr;
    logic [47:0]   wdata;
    logic          peek_ok;
    logic          rday_keep;
    logic [CW-1:0] cap;
    logic [CW-1:0] ndrop;
    logic [CW:0]   head_sum;

    assign rd_done   = (rd_pos_reg == fill_reg);
    assign issue     = cmd.exec || ((cmd.scan || cmd.rday) && !rd_done);
    assign peek_ok   = (pos_reg < 16'(fill_reg));
    assign rday_keep = cmd.rday && rvalid_reg && (rdata_reg[47:16] != day_reg);

    always_comb
    begin
        if (cmd.exec)
        begin
            raddr = ring({1'b0, head_reg} + (CW+1)'(pos_reg[CW-1:0]));
        end
        else
        begin
            raddr = ring({1'b0, head_reg} + (CW+1)'(rd_pos_reg));
        end
    end

    // drop count so that fill ends below the keep limit before the append
    always_comb
    begin
        if (keep_limit == 16'd0 || keep_limit > 16'(CAPACITY))
        begin
            cap = CW'(CAPACITY);
        end
        else
        begin
            cap = keep_limit[CW-1:0];
        end
        ndrop = '0;
        if (fill_reg >= cap)
        begin
            ndrop = fill_reg - cap + CW'(1);
        end
        head_sum = {1'b0, head_reg} + (CW+1)'(ndrop);
    end

    always_comb
    begin
        we    = 1'b0;
        waddr = ring({1'b0, head_reg} + (CW+1)'(fill_reg));
        wdata = {day_reg, idx_reg};
        if (cmd.append)
        begin
            we = 1'b1;
        end
        else if (rday_keep)
        begin
            // compaction stays behind the read pointer, so no unread slot is hit
            we    = 1'b1;
            waddr = ring({1'b0, head_reg} + (CW+1)'(kept_reg));
            wdata = rdata_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        // read data holds while the result waits for the receiver
        if (issue)
        begin
            rdata_reg <= mem[raddr];
        end
        if (cmd.accept)
        begin
            req_reg <= req_type;
            day_reg <= entry_day;
            idx_reg <= entry_index;
            pos_reg <= peek_position;
            n_reg   <= pop_count;
        end
        if (cmd.load)
        begin
            ok_reg   <= !(req_reg > 3'(drq_pkg::REQ_RDAY)) &&
                        !(req_reg == 3'(drq_pkg::REQ_PEEK) && !peek_ok);
            pres_reg <= dup_reg;
            if (req_reg == 3'(drq_pkg::REQ_PEEK) && peek_ok)
            begin
                oday_reg <= rdata_reg[47:16];
                oidx_reg <= rdata_reg[15:0];
            end
            else
            begin
                oday_reg <= '0;
                oidx_reg <= '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg      <= '0;
            fill_reg      <= '0;
            drop_reg      <= '0;
            rd_pos_reg    <= '0;
            kept_reg      <= '0;
            rvalid_reg    <= 1'b0;
            dup_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            rvalid_reg <= issue && !cmd.exec;
            if (issue && !cmd.exec)
            begin
                rd_pos_reg <= rd_pos_reg + CW'(1);
            end
            if (cmd.accept)
            begin
                rd_pos_reg <= '0;
                kept_reg   <= '0;
                dup_reg    <= 1'b0;
            end
            if (cmd.scan && sts.hit)
            begin
                dup_reg <= 1'b1;
            end
            if (rday_keep)
            begin
                kept_reg <= kept_reg + CW'(1);
            end
            if (cmd.rday_fin)
            begin
                fill_reg <= kept_reg;
            end
            if (cmd.append)
            begin
                head_reg <= ring(head_sum);
                fill_reg <= fill_reg - ndrop + CW'(1);
                drop_reg <= drop_reg + 32'(ndrop);
            end
            if (cmd.exec)
            begin
                case (req_reg)
                    drq_pkg::REQ_POP:
                    begin
                        if (n_reg >= 16'(fill_reg))
                        begin
                            fill_reg <= '0;
                            head_reg <= '0;
                        end
                        else
                        begin
                            head_reg <= ring({1'b0, head_reg} + (CW+1)'(n_reg[CW-1:0]));
                            fill_reg <= fill_reg - n_reg[CW-1:0];
                        end
                    end
                    drq_pkg::REQ_CLEAR:
                    begin
                        fill_reg <= '0;
                        head_reg <= '0;
                        drop_reg <= '0;
                    end
                    default:
                    begin
                    end
                endcase
            end
            if (cmd.load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign sts.hit      = rvalid_reg && (rdata_reg == {day_reg, idx_reg});
    assign sts.rd_done  = rd_done;
    assign sts.rvalid   = rvalid_reg;
    assign sts.out_free = !out_valid_reg || !out_stall;

    // result fields follow the counters as they stand at load
    logic [CW-1:0] qc_reg;
    logic [31:0]   dr_reg;
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            qc_reg <= fill_reg;
            dr_reg <= drop_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign ok          = ok_reg;
    assign was_present = pres_reg;
    assign out_day     = oday_reg;
    assign out_index   = oidx_reg;
    assign queue_count = qc_reg;
    assign drops       = dr_reg;

    a_fill_cap: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= CW'(CAPACITY))
        else $error("fill above capacity");
    a_kept_behind: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.rday |-> kept_reg <= rd_pos_reg)
        else $error("compaction write ahead of read");
    a_append_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.append |=> fill_reg != '0)
        else $error("append left queue empty");

endmodule

@@ hw/rtl/dedup_ring_queue_drop_oldest_unit.sv @@
// Top level of the dedup ring queue: config register and unit wiring.
//
// Requests arrive on the in channel (in_valid / in_stall) with req_type and
// their operand fields; each request gives exactly one result on the out
// channel (out_valid / out_stall). A transfer happens when valid is high and
// stall is low. One request is processed at a time.
// Steps per request, from its transfer to the result register:
//   peek, pop n, clear, undefined type: the execute state, then the load
//   push: duplicate scan reads one entry a cycle from the entry store (a hit
//     ends the scan early), then the append if no hit, then the load
//   remove day: same read pass, kept entries written back, then the load
// A new request is taken as soon as the previous result sits in the output
// register, even while the receiver stalls it; a further result waits there.
// keep_limit is written over the APB port at byte address 0.
// Reset empties the queue and zeroes the drop counter and keep_limit; the
// entry store itself needs no clearing.
module dedup_ring_queue_drop_oldest_unit
#(
    parameter int CAPACITY = drq_pkg::CAPACITY,
    localparam int CW = $clog2(CAPACITY + 1)
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [1:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready,
    input  logic          in_valid,
    output logic          in_stall,
    input  logic [2:0]    req_type,
    input  logic [31:0]   entry_day,
    input  logic [15:0]   entry_index,
    input  logic [15:0]   peek_position,
    input  logic [15:0]   pop_count,
    output logic          out_valid,
    input  logic          out_stall,
    output logic          ok,
    output logic          was_present,
    output logic [31:0]   out_day,
    output logic [15:0]   out_index,
    output logic [CW-1:0] queue_count,
    output logic [31:0]   drops
);

    logic [15:0]   keep_limit_reg;
    drq_pkg::cmd_t cmd;
    drq_pkg::sts_t sts;

    assign pready = 1'b1;
    assign prdata = (paddr == drq_pkg::ADDR_KEEP_LIMIT) ? {16'd0, keep_limit_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            keep_limit_reg <= '0;
        end
        else if (psel && penable && pwrite && paddr == drq_pkg::ADDR_KEEP_LIMIT)
        begin
            keep_limit_reg <= pwdata[15:0];
        end
    end

    drq_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .req_type (req_type),
        .sts      (sts),
        .cmd      (cmd),
        .in_stall (in_stall)
    );

    drq_dp #(.CAPACITY(CAPACITY)) u_dp
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .sts           (sts),
        .keep_limit    (keep_limit_reg),
        .req_type      (req_type),
        .entry_day     (entry_day),
        .entry_index   (entry_index),
        .peek_position (peek_position),
        .pop_count     (pop_count),
        .out_stall     (out_stall),
        .out_valid     (out_valid),
        .ok            (ok),
        .was_present   (was_present),
        .out_day       (out_day),
        .out_index     (out_index),
        .queue_count   (queue_count),
        .drops         (drops)
    );

endmodule

@@ sim/tb_dedup_ring_queue_drop_oldest_unit.sv @@
// Testbench for the dedup ring queue: directed and random requests checked against a predictor.
`timescale 1ns / 100ps

module tb_dedup_ring_queue_drop_oldest_unit;

    localparam logic [2:0] REQ_UNDEF_LO = 3'd5;
    localparam logic [2:0] REQ_UNDEF_HI = 3'd7;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int HOLD_CYCLES = 400;

    typedef struct {
        logic [31:0] day;
        logic [15:0] idx;
    } qref_t;

    typedef struct {
        logic        ok;
        logic        was_present;
        logic [31:0] day;
        logic [15:0] idx;
        logic [6:0]  count;
        logic [31:0] drops;
    } reply_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [1:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [2:0]  req_type = '0;
    logic [31:0] entry_day = '0;
    logic [15:0] entry_index = '0;
    logic [15:0] peek_position = '0;
    logic [15:0] pop_count = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic        ok;
    logic        was_present;
    logic [31:0] out_day;
    logic [15:0] out_index;
    logic [6:0]  queue_count;
    logic [31:0] drops;

    // predictor state
    qref_t       held_q[$];
    logic [31:0] drop_total = '0;
    logic [15:0] keep_lim = '0;
    reply_t      pending_q[$];

    int errors = 0;
    int send_idle_pct = 0;
    int stall_pct = 0;
    int hold_req = 0;
    int hold_seen = 0;
    int hold_left = 0;
    int cycles = 0;

    dedup_ring_queue_drop_oldest_unit uut (.*);

    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("FAIL dedup_ring_queue_drop_oldest_unit");
            $finish;
        end
    end

    // receiver: random stall plus an occasional long hold-off
    always @(posedge clk)
    begin
        if (hold_req != hold_seen)
        begin
            hold_seen = hold_req;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else
            out_stall <= ($urandom_range(99) < stall_pct);
    end

    always @(posedge clk)
    begin
        reply_t e;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_q.size() == 0)
            begin
                $error("result transfer with nothing expected");
                errors++;
            end
            else
            begin
                e = pending_q.pop_front();
                if (ok !== e.ok)
                begin
                    $error("ok: expected %0h actual %0h", e.ok, ok);
                    errors++;
                end
                if (was_present !== e.was_present)
                begin
                    $error("was_present: expected %0h actual %0h", e.was_present, was_present);
                    errors++;
                end
                if (out_day !== e.day)
                begin
                    $error("out_day: expected %0h actual %0h", e.day, out_day);
                    errors++;
                end
                if (out_index !== e.idx)
                begin
                    $error("out_index: expected %0h actual %0h", e.idx, out_index);
                    errors++;
                end
                if (queue_count !== e.count)
                begin
                    $error("queue_count: expected %0d actual %0d", e.count, queue_count);
                    errors++;
                end
                if (drops !== e.drops)
                begin
                    $error("drops: expected %0h actual %0h", e.drops, drops);
                    errors++;
                end
            end
        end
    end

    // expected reply for one accepted request; updates the queue image
    task automatic predict_reply(input logic [2:0] rq, input logic [31:0] day,
                                 input logic [15:0] idx, input logic [15:0] pos,
                                 input logic [15:0] n);
        reply_t r;
        qref_t  kept[$];
        int     lim;
        r = '{ok: 1'b1, was_present: 1'b0, day: '0, idx: '0, count: '0, drops: '0};
        if (rq == drq_pkg::REQ_PUSH)
        begin
            foreach (held_q[i])
                if (held_q[i].day == day && held_q[i].idx == idx)
                    r.was_present = 1'b1;
            if (!r.was_present)
            begin
                lim = (keep_lim == 0 || keep_lim > drq_pkg::CAPACITY) ? drq_pkg::CAPACITY
                                                                      : keep_lim;
                while (held_q.size() >= lim)
                begin
                    void'(held_q.pop_front());
                    drop_total++;
                end
                held_q.push_back('{day: day, idx: idx});
            end
        end
        else if (rq == drq_pkg::REQ_PEEK)
        begin
            if (pos < held_q.size())
            begin
                r.day = held_q[pos].day;
                r.idx = held_q[pos].idx;
            end
            else
                r.ok = 1'b0;
        end
        else if (rq == drq_pkg::REQ_POP)
        begin
            for (int i = 0; i < n && held_q.size() > 0; i++)
                void'(held_q.pop_front());
        end
        else if (rq == drq_pkg::REQ_CLEAR)
        begin
            held_q.delete();
            drop_total = '0;
        end
        else if (rq == drq_pkg::REQ_RDAY)
        begin
            foreach (held_q[i])
                if (held_q[i].day != day)
                    kept.push_back(held_q[i]);
            held_q = kept;
        end
        else
            r.ok = 1'b0;
        r.count = 7'(held_q.size());
        r.drops = drop_total;
        pending_q.push_back(r);
    endtask

    task automatic send_req(input logic [2:0] rq, input logic [31:0] day,
                            input logic [15:0] idx, input logic [15:0] pos,
                            input logic [15:0] n);
        int gap;
        in_valid      <= 1'b1;
        req_type      <= rq;
        entry_day     <= day;
        entry_index   <= idx;
        peek_position <= pos;
        pop_count     <= n;
        do @(posedge clk); while (in_stall);
        predict_reply(rq, day, idx, pos, n);
        if ($urandom_range(99) < send_idle_pct)
        begin
            gap = $urandom_range(1, 6);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (pending_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_keep_limit(input logic [15:0] v);
        wait_drained();
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        paddr   <= drq_pkg::ADDR_KEEP_LIMIT;
        pwdata  <= {16'h0, v};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        keep_lim = v;
    endtask

    task automatic test_directed();
        write_keep_limit(16'd0);
        send_req(drq_pkg::REQ_PEEK, 32'h0, 16'h0, 16'd0, 16'd0);
        send_req(drq_pkg::REQ_POP, 32'h0, 16'h0, 16'd0, 16'd0);
        send_req(drq_pkg::REQ_PUSH, 32'h0, 16'h0, 16'hFFFF, 16'hFFFF);
        send_req(drq_pkg::REQ_PUSH, 32'hFFFF_FFFF, 16'hFFFF, 16'h0, 16'h0);
        send_req(drq_pkg::REQ_PUSH, 32'hFFFF_FFFF, 16'hFFFF, 16'h0, 16'h0);
        send_req(drq_pkg::REQ_PUSH, 32'hFFFF_FFFF, 16'h0, 16'h0, 16'h0);
        send_req(drq_pkg::REQ_PEEK, 32'h0, 16'h0, 16'd2, 16'd0);
        send_req(drq_pkg::REQ_PEEK, 32'h0, 16'h0, 16'd3, 16'd0);
        send_req(drq_pkg::REQ_PEEK, 32'h0, 16'h0, 16'hFFFF, 16'd0);
        send_req(drq_pkg::REQ_POP, 32'h0, 16'h0, 16'd0, 16'd0);
        send_req(drq_pkg::REQ_RDAY, 32'h1234, 16'h0, 16'd0, 16'd0);
        send_req(drq_pkg::REQ_RDAY, 32'hFFFF_FFFF, 16'h0, 16'd0, 16'd0);
        send_req(drq_pkg::REQ_PEEK, 32'h0, 16'h0, 16'd0, 16'd0);
        send_req(REQ_UNDEF_LO, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_req(REQ_UNDEF_HI, 32'h0, 16'h0, 16'h0, 16'h0);
        send_req(drq_pkg::REQ_POP, 32'h0, 16'h0, 16'd0, 16'hFFFF);
        write_keep_limit(16'd2);
        for (int i = 0; i < 4; i++)
            send_req(drq_pkg::REQ_PUSH, 32'd7, 16'(i), 16'd0, 16'd0);
        send_req(drq_pkg::REQ_POP, 32'h0, 16'h0, 16'd0, 16'd1);
        send_req(drq_pkg::REQ_CLEAR, 32'h0, 16'h0, 16'd0, 16'd0);
        send_req(drq_pkg::REQ_PEEK, 32'h0, 16'h0, 16'd0, 16'd0);
    endtask

    task automatic random_req();
        logic [2:0]  rq;
        logic [31:0] day;
        logic [15:0] idx, pos, n;
        int          sel;
        sel = $urandom_range(99);
        if (sel < 50)      rq = drq_pkg::REQ_PUSH;
        else if (sel < 75) rq = drq_pkg::REQ_PEEK;
        else if (sel < 86) rq = drq_pkg::REQ_POP;
        else if (sel < 93) rq = drq_pkg::REQ_RDAY;
        else if (sel < 95) rq = drq_pkg::REQ_CLEAR;
        else               rq = 3'($urandom_range(REQ_UNDEF_LO, REQ_UNDEF_HI));
        // small pools make duplicates and day matches common
        day = ($urandom_range(9) == 0) ? 32'($urandom) : 32'($urandom_range(5));
        idx = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(15));
        pos = ($urandom_range(9) == 0) ? 16'($urandom)
                                       : 16'($urandom_range(held_q.size() + 1));
        n   = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(4));
        send_req(rq, day, idx, pos, n);
    endtask

    task automatic test_random_phase(input logic [15:0] lim, input int idle, input int stall,
                                     input int count);
        write_keep_limit(lim);
        send_idle_pct = idle;
        stall_pct = stall;
        repeat (count) random_req();
    endtask

    task automatic test_backpressure();
        send_idle_pct = 0;
        stall_pct = 0;
        hold_req++;
        repeat (30) random_req();
        // sender pause until every result is back
        wait_drained();
        repeat (20) random_req();
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random_phase(16'd0, 0, 0, 220);
        test_random_phase(16'd1, 68, 0, 120);
        test_random_phase(16'd65535, 0, 68, 200);
        test_random_phase(16'd64, 13, 13, 200);
        test_random_phase(16'd65, 68, 68, 100);
        test_random_phase(16'($urandom_range(2, 63)), 13, 13, 200);
        test_backpressure();
        wait_drained();
        repeat (100) @(posedge clk);
        if (errors == 0)
            $display("PASS dedup_ring_queue_drop_oldest_unit");
        else
            $display("FAIL dedup_ring_queue_drop_oldest_unit");
        $finish;
    end

endmodule
